[rtl/mspt_pkg.sv]
// Shared types and constants for the multichannel soft PWM table.
// Used by mspt_front, mspt_back and multichannel_soft_pwm_table_unit.
`default_nettype none
package mspt_pkg;

  localparam int CHANNELS = 8;
  localparam int PINS     = 32;

  localparam int SLOT_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PIN_W   = 5;
  localparam int CNT_W   = 16;
  localparam int LEN_W   = 32;
  localparam int LVL_W   = 32;
  localparam int IDX_W   = 3;
  localparam int KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SETUP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHANGE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_SETUP,
    OP_CHANGE,
    OP_RELEASE,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [PIN_W-1:0] pin;
    logic [CNT_W-1:0] period;
    logic [CNT_W-1:0] high_time;
    logic [LEN_W-1:0] length;
  } cmd_t;

  typedef struct packed {
    logic [LVL_W-1:0] pin_levels;
    logic             slot_found;
    logic [IDX_W-1:0] slot_index;
  } res_t;

endpackage
`default_nettype wire

[rtl/mspt_front.sv]
// Front end: accepts input items, classifies them into slot operations
// and holds them in a two-entry command queue. Depends on mspt_pkg.
`default_nettype none
module mspt_front (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      push,
  output logic                     full,
  input  wire [mspt_pkg::KIND_W-1:0] kind,
  input  wire [mspt_pkg::PIN_W-1:0]  pin,
  input  wire [mspt_pkg::CNT_W-1:0]  period,
  input  wire [mspt_pkg::CNT_W-1:0]  high_time,
  input  wire [mspt_pkg::LEN_W-1:0]  length,
  output logic                     cmd_valid,
  output mspt_pkg::cmd_t           cmd,
  input  wire                      cmd_take
);
  import mspt_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;
  logic       pin_ok;
  cmd_t       new_cmd;

  assign pin_ok = {1'b0, 32'(pin)} < {1'b0, 32'(PINS)};

  always_comb begin
    new_cmd.pin       = pin;
    new_cmd.period    = period;
    new_cmd.high_time = high_time;
    new_cmd.length    = length;
    unique case (kind)
      KIND_TICK:    new_cmd.op = OP_TICK;
      KIND_SETUP:   new_cmd.op = pin_ok ? OP_SETUP : OP_NONE;
      KIND_CHANGE:  new_cmd.op = pin_ok ? OP_CHANGE : OP_NONE;
      KIND_RELEASE: new_cmd.op = pin_ok ? OP_RELEASE : OP_NONE;
      default:      new_cmd.op = OP_NONE;
    endcase
  end

  assign full      = cnt_r == 2'd2;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

[rtl/mspt_back.sv]
// Back end: walks the slot table one slot per cycle to carry out a command,
// then loads the result register. Depends on mspt_pkg.
`default_nettype none
module mspt_back (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            cmd_valid,
  input  mspt_pkg::cmd_t cmd,
  output logic           cmd_take,
  output logic           res_valid,
  output mspt_pkg::res_t res,
  input  wire            res_pop
);
  import mspt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  cmd_t              cmd_r;
  logic              found_r, found_nxt;
  logic [SLOT_W-1:0] fidx_r, fidx_nxt;
  logic              res_valid_r;
  res_t              res_r;

  logic [CHANNELS-1:0] bound_r, bound_nxt;
  logic [CHANNELS-1:0] active_r, active_nxt;
  logic [PIN_W-1:0]    spin_r   [CHANNELS];
  logic [CNT_W-1:0]    phase_r  [CHANNELS];
  logic [CNT_W-1:0]    period_r [CHANNELS];
  logic [CNT_W-1:0]    low_r    [CHANNELS];
  logic [LEN_W-1:0]    rem_r    [CHANNELS];
  logic [PINS-1:0]     level_r, level_nxt;

  logic             c_active, c_same, last, hit;
  logic [PIN_W-1:0] c_pin;
  logic [CNT_W-1:0] c_phase, c_period, c_low, ph_inc;
  logic [LEN_W-1:0] c_rem;
  logic             wr_phase, wr_fields, wr_rem;
  logic [CNT_W-1:0] phase_w;
  logic [LEN_W-1:0] rem_w;
  logic [PINS-1:0]  tick_mask, cmd_mask;
  logic [63:0]      lvl_ext;
  logic [31:0]      idx_ext;

  assign c_active = active_r[slot_r];
  assign c_pin    = spin_r[slot_r];
  assign c_phase  = phase_r[slot_r];
  assign c_period = period_r[slot_r];
  assign c_low    = low_r[slot_r];
  assign c_rem    = rem_r[slot_r];
  assign c_same   = bound_r[slot_r] && (c_pin == cmd_r.pin);
  assign last     = slot_r == SLOT_W'(CHANNELS - 1);
  assign ph_inc   = c_phase + 16'd1;

  assign tick_mask = PINS'(1) << c_pin;
  assign cmd_mask  = PINS'(1) << cmd_r.pin;

  assign cmd_take  = (state_r == ST_IDLE) && cmd_valid && (!res_valid_r || res_pop);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    bound_nxt  = bound_r;
    active_nxt = active_r;
    level_nxt  = level_r;
    found_nxt  = found_r;
    fidx_nxt   = fidx_r;
    wr_phase   = 1'b0;
    wr_fields  = 1'b0;
    wr_rem     = 1'b0;
    phase_w    = c_phase;
    rem_w      = cmd_r.length;
    hit        = 1'b0;
    case (cmd_r.op)
      OP_SETUP:   hit = !found_r && (!c_active || c_same);
      OP_CHANGE:  hit = !found_r && c_same;
      OP_RELEASE: hit = !found_r && c_active && c_same;
      default:    hit = 1'b0;
    endcase
    if (state_r == ST_WALK) begin
      if (cmd_r.op == OP_TICK) begin
        if (c_active) begin
          if (c_phase == c_low) begin
            level_nxt = level_r & ~tick_mask;
          end else if (c_phase == '0) begin
            level_nxt = level_r | tick_mask;
          end
          if (c_rem != '0) begin
            wr_rem = 1'b1;
            rem_w  = c_rem - 32'd1;
            if (c_rem == 32'd1) begin
              active_nxt[slot_r] = 1'b0;
            end
          end
          wr_phase = 1'b1;
          phase_w  = (ph_inc >= c_period) ? '0 : ph_inc;
        end
      end else if (hit) begin
        found_nxt = 1'b1;
        fidx_nxt  = slot_r;
        case (cmd_r.op)
          OP_SETUP: begin
            bound_nxt[slot_r]  = 1'b1;
            active_nxt[slot_r] = 1'b1;
            wr_phase  = 1'b1;
            phase_w   = '0;
            wr_fields = 1'b1;
            wr_rem    = 1'b1;
          end
          OP_CHANGE: begin
            active_nxt[slot_r] = 1'b1;
            wr_fields = 1'b1;
            wr_rem    = 1'b1;
          end
          default: begin
            bound_nxt[slot_r]  = 1'b0;
            active_nxt[slot_r] = 1'b0;
            level_nxt = level_r & ~cmd_mask;
          end
        endcase
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        slot_nxt = '0;
        if (cmd_take) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        slot_nxt = slot_r + SLOT_W'(1);
        if (last) begin
          state_nxt = ST_IDLE;
          slot_nxt  = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        slot_nxt  = '0;
      end
    endcase
  end

  assign lvl_ext = 64'(level_nxt);
  assign idx_ext = 32'(fidx_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      found_r     <= 1'b0;
      fidx_r      <= '0;
      res_valid_r <= 1'b0;
      bound_r     <= '0;
      active_r    <= '0;
      level_r     <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        phase_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      slot_r   <= slot_nxt;
      bound_r  <= bound_nxt;
      active_r <= active_nxt;
      level_r  <= level_nxt;
      if (cmd_take) begin
        found_r <= 1'b0;
        fidx_r  <= '0;
      end else begin
        found_r <= found_nxt;
        fidx_r  <= fidx_nxt;
      end
      if (wr_phase) begin
        phase_r[slot_r] <= phase_w;
      end
      // result register frees on a transfer, fills when the walk ends
      if (state_r == ST_WALK && last) begin
        res_valid_r <= 1'b1;
      end else if (res_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_r <= cmd;
    end
    if (wr_fields) begin
      spin_r[slot_r]   <= cmd_r.pin;
      period_r[slot_r] <= cmd_r.period;
      low_r[slot_r]    <= cmd_r.high_time;
    end
    if (wr_rem) begin
      rem_r[slot_r] <= rem_w;
    end
    if (state_r == ST_WALK && last) begin
      res_r.pin_levels <= lvl_ext[LVL_W-1:0];
      res_r.slot_found <= found_nxt;
      res_r.slot_index <= idx_ext[IDX_W-1:0];
    end
  end

endmodule
`default_nettype wire

[rtl/multichannel_soft_pwm_table_unit.sv]
// Top level of the multichannel soft PWM table: front queue plus slot walker.
// Depends on mspt_pkg, mspt_front and mspt_back.
//
// Input channel: present kind, pin, period, high_time and length with push;
// a transfer happens on a clock edge with push high and full low. Up to two
// items wait in the command queue while the slot walker is busy.
// Result channel: while empty is low the oldest result (pin levels, slot
// found flag, slot index) is on the out_ ports; it transfers on an edge with
// pop high. Exactly one result per input item, in order.
// Every item, tick or command, walks all CHANNELS slots one per cycle in the
// back end; the walker takes a new item only from idle, after the last slot,
// and the result register is loaded as the walk of the last slot ends.
// The walker starts an item only once the result register is free, so a
// stalled receiver backs up into the command queue and then raises full.
// Synchronous reset clears all slots to unbound and inactive, all phase
// counts and pin levels to zero, and empties both queues.
`default_nettype none
module multichannel_soft_pwm_table_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          push,
  output logic                         full,
  input  wire [mspt_pkg::KIND_W-1:0]   in_kind,
  input  wire [mspt_pkg::PIN_W-1:0]    in_pin,
  input  wire [mspt_pkg::CNT_W-1:0]    in_period,
  input  wire [mspt_pkg::CNT_W-1:0]    in_high_time,
  input  wire [mspt_pkg::LEN_W-1:0]    in_length,
  output logic                         empty,
  input  wire                          pop,
  output logic [mspt_pkg::LVL_W-1:0]   out_pin_levels,
  output logic                         out_slot_found,
  output logic [mspt_pkg::IDX_W-1:0]   out_slot_index
);
  import mspt_pkg::*;

  logic cmd_valid, cmd_take, res_valid;
  cmd_t cmd;
  res_t res;

  mspt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .kind      (in_kind),
    .pin       (in_pin),
    .period    (in_period),
    .high_time (in_high_time),
    .length    (in_length),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  mspt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  assign empty          = !res_valid;
  assign out_pin_levels = res.pin_levels;
  assign out_slot_found = res.slot_found;
  assign out_slot_index = res.slot_index;

endmodule
`default_nettype wire
